>>> rtl/core/rrt_pkg.sv
// Shared types and constants of the received range tracker.
package rrt_pkg;

    localparam int RING_DEPTH  = 16;
    localparam int VALUE_WIDTH = 48;
    localparam int IDX_W       = $clog2(RING_DEPTH);
    localparam int CNT_W       = $clog2(RING_DEPTH + 1);

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [CNT_W-1:0]       cnt_t;

    // Command codes
    localparam logic [1:0] CMD_INCLUDE = 2'd0;
    localparam logic [1:0] CMD_EXCLUDE = 2'd1;
    localparam logic [1:0] CMD_QUERY   = 2'd2;
    localparam logic [1:0] CMD_CLEAR   = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_ROOM = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE       = 4'd0,
        OP_LOAD       = 4'd1,  // capture the request
        OP_FAST       = 4'd2,  // head-based include decision
        OP_SCAN_OVL   = 4'd3,  // overlap check of entry ptr
        OP_SCAN_ADJ   = 4'd4,  // adjacency search at entry ptr
        OP_SCAN_GAP   = 4'd5,  // gap search at entry ptr
        OP_SHIFT_DOWN = 4'd6,  // one step of dropping an entry
        OP_SHIFT_UP   = 4'd7,  // one step of making room
        OP_EXCL       = 4'd8,  // exclude step at ptr
        OP_QUERY      = 4'd9,  // query step at ptr
        OP_CLEAR      = 4'd10, // clear step at ptr
        OP_ROOM       = 4'd11, // set up shifting from the head to the gap slot
        OP_FINISH     = 4'd12  // write the new range at the gap slot
    } op_t;

    typedef struct packed {
        op_t  op;
        logic ptr_zero;
        logic ptr_inc;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       fast_done;   // include finished by head logic
        logic [1:0] fast_status; // status of an include finished by head logic
        logic       hit;         // scan found its condition at ptr
        logic       merge;       // adjacency hit joins two entries
        logic       ptr_last;    // ptr is the last entry
        logic       shift_done;  // shift sequence complete
        logic       room_ok;
        logic       room_need;   // slot occupied, shifting required
    } dp_stat_t;

endpackage

>>> rtl/core/rrt_datapath.sv
// Range store, scan pointer and per-entry arithmetic of the range tracker.
module rrt_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rrt_pkg::dp_cmd_t      ctl,
    output rrt_pkg::dp_stat_t     stat,
    input  logic [1:0]            in_cmd,
    input  rrt_pkg::value_t       in_lo,
    input  rrt_pkg::value_t       in_hi,
    input  rrt_pkg::value_t       min_hist,
    input  logic                  set_status,
    input  logic [1:0]            status_val,
    output logic [1:0]            status,
    output logic                  any_overlap
);
    localparam int D = rrt_pkg::RING_DEPTH;

    rrt_pkg::value_t start_reg [D];
    rrt_pkg::value_t end_reg   [D];
    rrt_pkg::value_t lo_reg, hi_reg;
    logic [1:0]      cmd_reg;
    rrt_pkg::idx_t   head_reg, ptr_reg, stop_reg;
    logic            any_reg;
    logic [1:0]      status_reg;

    function automatic rrt_pkg::idx_t nxt(rrt_pkg::idx_t k);
        nxt = (k == rrt_pkg::idx_t'(D - 1)) ? '0 : k + 1'b1;
    endfunction
    function automatic rrt_pkg::idx_t prv(rrt_pkg::idx_t k);
        prv = (k == '0) ? rrt_pkg::idx_t'(D - 1) : k - 1'b1;
    endfunction

    // Entry reads at the pointer, its neighbours and the head
    rrt_pkg::value_t ps, pe, pn_s, pp_e, he, te, hn_e;
    rrt_pkg::idx_t   pn, pp, hn;
    logic            hist_ok;
    rrt_pkg::value_t amax, bmin;

    always_comb begin
        pn   = nxt(ptr_reg);
        pp   = prv(ptr_reg);
        hn   = nxt(head_reg);
        ps   = start_reg[ptr_reg];
        pe   = end_reg[ptr_reg];
        pn_s = start_reg[pn];
        pp_e = end_reg[pp];
        he   = end_reg[head_reg];
        hn_e = end_reg[hn];
        te   = end_reg[hn];
        hist_ok = (hi_reg > min_hist) && (hn_e < hi_reg - min_hist);
        amax = (ps > lo_reg) ? ps : lo_reg;
        bmin = (pe < hi_reg) ? pe : hi_reg;
    end

    // Status towards the controller
    always_comb begin
        stat.cmd        = cmd_reg;
        stat.fast_done  = (lo_reg >= hi_reg) || (he == '0) || (he == lo_reg) || (he < lo_reg);
        stat.ptr_last   = (ptr_reg == rrt_pkg::idx_t'(D - 1));
        stat.shift_done = (ptr_reg == stop_reg);
        stat.room_need  = (pe != '0);
        stat.room_ok    = (te == '0) || !((hi_reg < min_hist) || (te >= hi_reg - min_hist));
        // An end-touching hit merges when the new end meets the next start,
        // a start-touching hit when the previous end meets the new start.
        stat.merge      = (pe != '0 && pe == lo_reg) ? (hi_reg == pn_s) : (pp_e == lo_reg);
        priority if (lo_reg >= hi_reg) begin
            stat.fast_status = rrt_pkg::ST_INVALID;
        end else if ((he == '0) || (he == lo_reg)) begin
            stat.fast_status = rrt_pkg::ST_OK;
        end else if ((he < lo_reg) && !((hn_e == '0) || hist_ok)) begin
            stat.fast_status = rrt_pkg::ST_NO_ROOM;
        end else begin
            stat.fast_status = rrt_pkg::ST_OK;
        end
        unique case (ctl.op)
            rrt_pkg::OP_SCAN_OVL:
                stat.hit = (pe != '0) && !((hi_reg <= ps) || (lo_reg >= pe));
            rrt_pkg::OP_SCAN_ADJ:
                stat.hit = (pe != '0) && ((pe == lo_reg) || (ps == hi_reg));
            rrt_pkg::OP_SCAN_GAP:
                stat.hit = (pp_e < lo_reg) && (hi_reg < ps);
            default: stat.hit = 1'b0;
        endcase
    end

    // Register and store updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < D; i++) begin
                start_reg[i] <= '0;
                end_reg[i]   <= '0;
            end
            head_reg   <= '0;
            ptr_reg    <= '0;
            stop_reg   <= '0;
            any_reg    <= 1'b0;
            status_reg <= rrt_pkg::ST_OK;
            cmd_reg    <= rrt_pkg::CMD_INCLUDE;
        end else begin
            if (ctl.ptr_zero) ptr_reg <= '0;
            else if (ctl.ptr_inc) ptr_reg <= pn;
            if (set_status) status_reg <= status_val;
            unique case (ctl.op)
                rrt_pkg::OP_LOAD: begin
                    cmd_reg <= in_cmd;
                    lo_reg  <= in_lo;
                    hi_reg  <= in_hi;
                    any_reg <= 1'b0;
                end
                rrt_pkg::OP_FAST: begin
                    if (lo_reg >= hi_reg) begin
                        // empty range: nothing changes
                    end else if (he == '0) begin
                        start_reg[head_reg] <= lo_reg;
                        end_reg[head_reg]   <= hi_reg;
                    end else if (he == lo_reg) begin
                        end_reg[head_reg] <= hi_reg;
                    end else if (he < lo_reg) begin
                        if ((hn_e == '0) || hist_ok) begin
                            start_reg[hn] <= lo_reg;
                            end_reg[hn]   <= hi_reg;
                            head_reg      <= hn;
                        end
                    end
                end
                rrt_pkg::OP_SCAN_ADJ: begin
                    if (pe != '0 && pe == lo_reg) begin
                        // extend end, merge with the next entry if it touches
                        if (hi_reg == pn_s) begin
                            end_reg[ptr_reg] <= end_reg[pn];
                            ptr_reg  <= pn;
                            stop_reg <= head_reg;
                        end else begin
                            end_reg[ptr_reg] <= hi_reg;
                        end
                    end else if (pe != '0 && ps == hi_reg) begin
                        if (pp_e == lo_reg) begin
                            end_reg[pp] <= pe;
                            stop_reg <= head_reg;
                        end else begin
                            start_reg[ptr_reg] <= lo_reg;
                        end
                    end
                end
                rrt_pkg::OP_SHIFT_DOWN: begin
                    if (ptr_reg != stop_reg) begin
                        start_reg[ptr_reg] <= pn_s;
                        end_reg[ptr_reg]   <= end_reg[pn];
                        ptr_reg <= pn;
                    end else begin
                        start_reg[ptr_reg] <= '0;
                        end_reg[ptr_reg]   <= '0;
                        head_reg <= pp;
                    end
                end
                rrt_pkg::OP_ROOM: begin
                    // ptr holds the gap slot; shift from the head upward
                    stop_reg <= ptr_reg;
                    ptr_reg  <= hn;
                end
                rrt_pkg::OP_SHIFT_UP: begin
                    if (ptr_reg != stop_reg) begin
                        start_reg[ptr_reg] <= start_reg[pp];
                        end_reg[ptr_reg]   <= pp_e;
                        ptr_reg <= pp;
                    end else begin
                        head_reg <= hn;
                    end
                end
                rrt_pkg::OP_FINISH: begin
                    start_reg[ptr_reg] <= lo_reg;
                    end_reg[ptr_reg]   <= hi_reg;
                end
                rrt_pkg::OP_EXCL: begin
                    if (pe <= hi_reg) begin
                        start_reg[ptr_reg] <= '0;
                        end_reg[ptr_reg]   <= '0;
                    end else if (ps < hi_reg) begin
                        start_reg[ptr_reg] <= hi_reg;
                    end
                end
                rrt_pkg::OP_QUERY: begin
                    if (amax < bmin) any_reg <= 1'b1;
                end
                rrt_pkg::OP_CLEAR: begin
                    start_reg[ptr_reg] <= '0;
                    end_reg[ptr_reg]   <= '0;
                    head_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    assign status      = status_reg;
    assign any_overlap = any_reg;
endmodule

>>> rtl/core/rrt_ctrl.sv
// Sequencing state machine of the received range tracker.
module rrt_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    output logic                busy,
    output logic                done,
    output rrt_pkg::dp_cmd_t    ctl,
    input  rrt_pkg::dp_stat_t   stat,
    output logic                set_status,
    output logic [1:0]          status_val
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DISP  = 10'b0000000010,
        S_OVL   = 10'b0000000100,
        S_ADJ   = 10'b0000001000,
        S_GAP   = 10'b0000010000,
        S_DOWN  = 10'b0000100000,
        S_ROOM  = 10'b0001000000,
        S_UP    = 10'b0010000000,
        S_SCAN  = 10'b0100000000,
        S_FIN   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    // Next state and datapath command
    always_comb begin
        state_next   = state_reg;
        ctl.op       = rrt_pkg::OP_NONE;
        ctl.ptr_zero = 1'b0;
        ctl.ptr_inc  = 1'b0;
        set_status   = 1'b0;
        status_val   = rrt_pkg::ST_OK;
        done         = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    ctl.op = rrt_pkg::OP_LOAD;
                    ctl.ptr_zero = 1'b1;
                    set_status = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                if (stat.cmd == rrt_pkg::CMD_INCLUDE) begin
                    ctl.op = rrt_pkg::OP_FAST;
                    if (stat.fast_done) begin
                        // decision made from the head entry
                        set_status = 1'b1;
                        status_val = stat.fast_status;
                        done = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_OVL;
                    end
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_OVL: begin
                ctl.op = rrt_pkg::OP_SCAN_OVL;
                if (stat.hit) begin
                    set_status = 1'b1;
                    status_val = rrt_pkg::ST_INVALID;
                    done = 1'b1;
                    state_next = S_IDLE;
                end else if (stat.ptr_last) begin
                    ctl.ptr_zero = 1'b1;
                    state_next = S_ADJ;
                end else ctl.ptr_inc = 1'b1;
            end
            S_ADJ: begin
                ctl.op = rrt_pkg::OP_SCAN_ADJ;
                if (stat.hit) begin
                    // a plain extension ends here, a merge drops an entry
                    if (stat.merge) state_next = S_DOWN;
                    else begin
                        done = 1'b1;
                        state_next = S_IDLE;
                    end
                end else if (stat.ptr_last) begin
                    ctl.ptr_zero = 1'b1;
                    state_next = S_GAP;
                end else ctl.ptr_inc = 1'b1;
            end
            S_DOWN: begin
                ctl.op = rrt_pkg::OP_SHIFT_DOWN;
                if (stat.shift_done) begin
                    done = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_GAP: begin
                ctl.op = rrt_pkg::OP_SCAN_GAP;
                if (stat.hit) begin
                    if (!stat.room_need) state_next = S_FIN;
                    else if (!stat.room_ok) begin
                        set_status = 1'b1;
                        status_val = rrt_pkg::ST_NO_ROOM;
                        done = 1'b1;
                        state_next = S_IDLE;
                    end else state_next = S_ROOM;
                end else if (stat.ptr_last) begin
                    set_status = 1'b1;
                    status_val = rrt_pkg::ST_NO_ROOM;
                    done = 1'b1;
                    state_next = S_IDLE;
                end else ctl.ptr_inc = 1'b1;
            end
            S_ROOM: begin
                ctl.op = rrt_pkg::OP_ROOM;
                state_next = S_UP;
            end
            S_UP: begin
                ctl.op = rrt_pkg::OP_SHIFT_UP;
                if (stat.shift_done) state_next = S_FIN;
            end
            S_FIN: begin
                ctl.op = rrt_pkg::OP_FINISH;
                done = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN: begin
                unique case (stat.cmd)
                    rrt_pkg::CMD_EXCLUDE: ctl.op = rrt_pkg::OP_EXCL;
                    rrt_pkg::CMD_QUERY:   ctl.op = rrt_pkg::OP_QUERY;
                    default:              ctl.op = rrt_pkg::OP_CLEAR;
                endcase
                if (stat.ptr_last) begin
                    done = 1'b1;
                    state_next = S_IDLE;
                end else ctl.ptr_inc = 1'b1;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
endmodule

>>> rtl/core/received_range_tracker_unit.sv
// Top level of the received range tracker: stream ports, result register and config.
// The block keeps sixteen [start,end) ranges and takes one request at a time. An in-order
// include is decided from the head entry in the dispatch state; its result then passes
// the pending and output registers, and the next request is taken once it leaves the
// pending register. Exclude, query and clear walk all entries; an out-of-order include
// scans the ring for overlap, then for a neighbour or gap, and shifts entries one per cycle.
// A stalled result side holds the result in the pending register and blocks requests. A result
// waits in its output register while the next request is taken.
module received_range_tracker_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // cmd[1:0], low_value[49:2], high_value[97:50], zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,   // status[1:0], any_overlap[2], zero pad
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [47:0]  cfg_data
);
    rrt_pkg::value_t  min_hist_reg;
    rrt_pkg::dp_cmd_t ctl;
    rrt_pkg::dp_stat_t stat;
    logic busy, done, start, set_status;
    logic [1:0] status_val, status;
    logic any_ov, pend_reg, mvalid_reg;
    logic [2:0] mdata_reg;

    // Configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) min_hist_reg <= '0;
        else if (cfg_valid) min_hist_reg <= cfg_data;
    end

    // Accept when idle and no finished result is still waiting behind the output
    assign s_tready = !busy && !pend_reg;
    assign start    = s_tvalid && s_tready;

    rrt_ctrl u_ctrl (
        .aclk, .aresetn, .start, .busy, .done, .ctl, .stat,
        .set_status, .status_val
    );

    rrt_datapath u_dp (
        .aclk, .aresetn, .ctl, .stat,
        .in_cmd(s_tdata[1:0]), .in_lo(s_tdata[49:2]), .in_hi(s_tdata[97:50]),
        .min_hist(min_hist_reg), .set_status, .status_val,
        .status, .any_overlap(any_ov)
    );

    // Fast-path include status is decided in the cycle it completes
    logic [1:0] fin_status;
    logic       fin_pending;
    assign fin_pending = done;

    // Result capture: in the cycle after done the datapath status is settled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            if (fin_pending) pend_reg <= 1'b1;
            else if (pend_reg && (!mvalid_reg || m_tready)) pend_reg <= 1'b0;
            if (pend_reg && (!mvalid_reg || m_tready)) mvalid_reg <= 1'b1;
            else if (m_tready) mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_reg && (!mvalid_reg || m_tready)) mdata_reg <= {any_ov, fin_status};
    end

    assign fin_status = status;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {5'b0, mdata_reg};
endmodule
